/* rtl/core/imu_dead_reckoning_integrator_defines.svh */
// assertion helpers for the imu dead reckoning integrator
`ifndef IMU_DEAD_RECKONING_INTEGRATOR_DEFINES_SVH
`define IMU_DEAD_RECKONING_INTEGRATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define IDR_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("imu integrator check failed");
`define IDR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("imu integrator check failed");
`else
`define IDR_ASSERT(label, ante, cons)
`define IDR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/core/idr_pkg.sv */
package idr_pkg;

  localparam int DT_W    = 24;
  localparam int SMP_W   = 24;
  localparam int ST_W    = 32;
  localparam int GAIN_W  = 16;
  localparam int DB_W    = 23;
  localparam int MULA_W  = 33;
  localparam int MULB_W  = 25;
  localparam int PROD_W  = MULA_W + MULB_W;
  localparam int ACC_W   = 60;
  localparam int DV_W    = 30;
  localparam int DIVR_W  = 21;
  localparam int DIVQ_W  = 40;
  localparam int DIVN_W  = 59;
  localparam int DIV_DIGITS = 4;
  localparam int DIV_STEPS  = DIVQ_W / DIV_DIGITS;
  localparam int DIVC_W  = $clog2(DIV_STEPS);
  localparam int PC_W    = 5;
  localparam int STAT_W  = 2;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam logic [PC_W-1:0] UC_LAST = PC_W'(16);

  // result status
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO = 2'd1;
  localparam logic [STAT_W-1:0] ST_LONG = 2'd2;

  // register indexes
  localparam logic [2:0] REG_ACCEL_GAIN = 3'd0;
  localparam logic [2:0] REG_RATE_GAIN  = 3'd1;
  localparam logic [2:0] REG_ACCEL_DB   = 3'd2;
  localparam logic [2:0] REG_RATE_DB    = 3'd3;
  localparam logic [2:0] REG_MAX_DT     = 3'd4;

  localparam logic [GAIN_W-1:0] ACCEL_GAIN_RST = 16'd6554;
  localparam logic [GAIN_W-1:0] RATE_GAIN_RST  = 16'd13107;
  localparam logic [DB_W-1:0]   ACCEL_DB_RST   = 23'd3277;
  localparam logic [DB_W-1:0]   RATE_DB_RST    = 23'd197;
  localparam logic [DT_W-1:0]   MAX_DT_RST     = 24'd100000;

  localparam logic [DIVR_W-1:0] DIV_1M  = 21'd1000000;
  localparam logic [DIVR_W-1:0] DIV_2M  = 21'd2000000;
  localparam logic [DIVR_W-1:0] HALF_1M = 21'd500000;
  localparam logic [DIVR_W-1:0] HALF_2M = 21'd1000000;

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

  // multiplier operand selects
  localparam logic [2:0] A_GA  = 3'd0;
  localparam logic [2:0] A_TMP = 3'd1;
  localparam logic [2:0] A_VEL = 3'd2;
  localparam logic [2:0] A_DV  = 3'd3;
  localparam logic [2:0] A_OMG = 3'd4;
  localparam logic [2:0] A_GR  = 3'd5;

  localparam logic [2:0] B_AIN = 3'd0;
  localparam logic [2:0] B_GA  = 3'd1;
  localparam logic [2:0] B_DT  = 3'd2;
  localparam logic [2:0] B_RP  = 3'd3;
  localparam logic [2:0] B_RZ  = 3'd4;

  // rounding shift by 2^16 into the temp register
  localparam logic [1:0] RND_NONE  = 2'd0;
  localparam logic [1:0] RND_PLAIN = 2'd1;
  localparam logic [1:0] RND_ACCEL = 2'd2;
  localparam logic [1:0] RND_RATE  = 2'd3;

  localparam logic DIV_SEL_1M = 1'b0;
  localparam logic DIV_SEL_2M = 1'b1;

  // write-back of the divider result
  localparam logic [2:0] WR_NONE = 3'd0;
  localparam logic [2:0] WR_DV   = 3'd1;
  localparam logic [2:0] WR_PACC = 3'd2;
  localparam logic [2:0] WR_POS  = 3'd3;
  localparam logic [2:0] WR_ANG  = 3'd4;

  localparam logic [1:0] JMP_NONE = 2'd0;
  localparam logic [1:0] JMP_AXIS = 2'd1;
  localparam logic [1:0] JMP_END  = 2'd2;

  typedef struct packed {
    logic       mul_en;
    logic [2:0] a_sel;
    logic [2:0] b_sel;
    logic [1:0] rnd_op;
    logic       rnd_acc;
    logic       acc_ld;
    logic       div_start;
    logic       div_sel;
    logic       wait_div;
    logic [2:0] wr_op;
    logic [1:0] jmp;
  } ucode_t;

  function automatic ucode_t mk(input logic mul_en, input logic [2:0] a_sel,
                                input logic [2:0] b_sel, input logic [1:0] rnd_op,
                                input logic rnd_acc, input logic acc_ld,
                                input logic div_start, input logic div_sel,
                                input logic wait_div, input logic [2:0] wr_op,
                                input logic [1:0] jmp);
    ucode_t w;
    w.mul_en    = mul_en;
    w.a_sel     = a_sel;
    w.b_sel     = b_sel;
    w.rnd_op    = rnd_op;
    w.rnd_acc   = rnd_acc;
    w.acc_ld    = acc_ld;
    w.div_start = div_start;
    w.div_sel   = div_sel;
    w.wait_div  = wait_div;
    w.wr_op     = wr_op;
    w.jmp       = jmp;
    return w;
  endfunction

  // control store: steps 0..10 run once per axis, 11..16 do the rate
  function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      5'd0:  w = mk(1'b1, A_GA,  B_AIN, RND_NONE,  1'b0, 1'b0, 1'b0, DIV_SEL_1M, 1'b0,
                    WR_NONE, JMP_NONE);
      5'd1:  w = mk(1'b0, A_GA,  B_GA,  RND_ACCEL, 1'b0, 1'b0, 1'b0, DIV_SEL_1M, 1'b0,
                    WR_NONE, JMP_NONE);
      5'd2:  w = mk(1'b1, A_TMP, B_GA,  RND_NONE,  1'b0, 1'b0, 1'b0, DIV_SEL_1M, 1'b0,
                    WR_NONE, JMP_NONE);
      5'd3:  w = mk(1'b0, A_GA,  B_GA,  RND_PLAIN, 1'b0, 1'b0, 1'b0, DIV_SEL_1M, 1'b0,
                    WR_NONE, JMP_NONE);
      5'd4:  w = mk(1'b1, A_TMP, B_DT,  RND_NONE,  1'b0, 1'b0, 1'b0, DIV_SEL_1M, 1'b0,
                    WR_NONE, JMP_NONE);
      5'd5:  w = mk(1'b0, A_GA,  B_GA,  RND_NONE,  1'b0, 1'b0, 1'b1, DIV_SEL_1M, 1'b0,
                    WR_NONE, JMP_NONE);
      5'd6:  w = mk(1'b1, A_VEL, B_DT,  RND_NONE,  1'b0, 1'b0, 1'b0, DIV_SEL_1M, 1'b1,
                    WR_DV, JMP_NONE);
      5'd7:  w = mk(1'b1, A_DV,  B_DT,  RND_NONE,  1'b0, 1'b0, 1'b1, DIV_SEL_1M, 1'b0,
                    WR_NONE, JMP_NONE);
      5'd8:  w = mk(1'b0, A_GA,  B_GA,  RND_NONE,  1'b0, 1'b0, 1'b0, DIV_SEL_1M, 1'b1,
                    WR_PACC, JMP_NONE);
      5'd9:  w = mk(1'b0, A_GA,  B_GA,  RND_NONE,  1'b0, 1'b0, 1'b1, DIV_SEL_2M, 1'b0,
                    WR_NONE, JMP_NONE);
      5'd10: w = mk(1'b0, A_GA,  B_GA,  RND_NONE,  1'b0, 1'b0, 1'b0, DIV_SEL_1M, 1'b1,
                    WR_POS, JMP_AXIS);
      5'd11: w = mk(1'b1, A_OMG, B_RP,  RND_NONE,  1'b0, 1'b0, 1'b0, DIV_SEL_1M, 1'b0,
                    WR_NONE, JMP_NONE);
      5'd12: w = mk(1'b1, A_GR,  B_RZ,  RND_NONE,  1'b0, 1'b1, 1'b0, DIV_SEL_1M, 1'b0,
                    WR_NONE, JMP_NONE);
      5'd13: w = mk(1'b0, A_GA,  B_GA,  RND_RATE,  1'b1, 1'b0, 1'b0, DIV_SEL_1M, 1'b0,
                    WR_NONE, JMP_NONE);
      5'd14: w = mk(1'b1, A_TMP, B_DT,  RND_NONE,  1'b0, 1'b0, 1'b0, DIV_SEL_1M, 1'b0,
                    WR_NONE, JMP_NONE);
      5'd15: w = mk(1'b0, A_GA,  B_GA,  RND_NONE,  1'b0, 1'b0, 1'b1, DIV_SEL_1M, 1'b0,
                    WR_NONE, JMP_NONE);
      5'd16: w = mk(1'b0, A_GA,  B_GA,  RND_NONE,  1'b0, 1'b0, 1'b0, DIV_SEL_1M, 1'b1,
                    WR_ANG, JMP_END);
      default: w = mk(1'b0, A_GA, B_GA, RND_NONE, 1'b0, 1'b0, 1'b0, DIV_SEL_1M, 1'b0,
                      WR_NONE, JMP_END);
    endcase
    return w;
  endfunction

  function automatic logic signed [ST_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ST_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[ST_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[ST_W-1:0];
    end else begin
      r = v[ST_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/core/imu_dead_reckoning_integrator.sv */
// IMU dead-reckoning integrator. Each accepted sample (interval in microseconds, x/y/z
// acceleration, z rate) yields exactly one result holding status, position, velocity,
// heading and filtered rate after the sample. A sample is accepted only while the block
// is idle, so the next sample is taken only after the result of the last one has been
// registered; a sample with a zero or too-long interval skips the computation. The work
// is done by a 17-step microcode program driving one 33x25
// multiplier and one restoring divider that retires four quotient bits a cycle: each
// of the ten divisions by 1e6 or 2e6 holds the sequence until the divider is done. All values are
// two's complement fixed point; velocity, position and heading saturate at 32 bits.
// Configuration registers live at byte offsets 0, 4, 8, 12 and 16 and are meant to
// be written only while no sample is in flight.
`include "imu_dead_reckoning_integrator_defines.svh"

module imu_dead_reckoning_integrator (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // interval_us, accel_x, accel_y, accel_z, rate_z
  input  logic [119:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, heading, filtered_rate
  output logic [247:0] out_tdata,
  // status
  output logic [1:0]   out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import idr_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [PC_W-1:0] pc_r;
  logic [1:0] ax_r;

  logic [GAIN_W-1:0] ga_r, gr_r;
  logic [DB_W-1:0]   adb_r, rdb_r;
  logic [DT_W-1:0]   maxdt_r;

  logic signed [ST_W-1:0]  vel_r [3];
  logic signed [ST_W-1:0]  pos_r [3];
  logic signed [ST_W-1:0]  angle_r;
  logic signed [SMP_W-1:0] rate_prev_r;

  logic [DT_W-1:0]         dt_r;
  logic signed [SMP_W-1:0] ain_r [3];
  logic signed [SMP_W-1:0] rz_r;
  logic [STAT_W-1:0]       status_r;

  logic signed [SMP_W-1:0]  tmp_r;
  logic signed [DV_W-1:0]   dv_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic              div_busy_r, div_neg_r, div_dsel_r;
  logic [DIVC_W-1:0] div_cnt_r;
  logic [DIVR_W-1:0] div_rem_r;
  logic [DIVQ_W-1:0] div_quo_r;

  logic              out_tvalid_r;
  logic [247:0]      out_data_r;
  logic [STAT_W-1:0] out_user_r;

  ucode_t uc;
  logic go, run_go, accept, out_free, cfg_wr;
  logic [DT_W-1:0] in_dt;
  logic [STAT_W-1:0] in_status;

  logic signed [ST_W-1:0]  vel_sel, pos_sel;
  logic signed [SMP_W-1:0] ain_sel;
  logic signed [MULA_W-1:0] mul_a;
  logic signed [MULB_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_c;
  logic [GAIN_W:0] omg;

  logic signed [ACC_W-1:0] rnd_sum;
  logic [ACC_W-1:0]        rnd_mag, rnd_sh;
  logic [SMP_W-1:0]        rnd_m;
  logic signed [SMP_W:0]   rnd_s;
  logic                    rnd_dead;
  logic signed [SMP_W-1:0] rnd_val;

  logic [PROD_W-1:0]       prod_mag;
  logic [DIVN_W-1:0]       div_n;
  logic [DIVR_W-1:0]       dvsr;
  logic [DIVR_W-1:0]       rem_c;
  logic [DIVQ_W-1:0]       quo_c;
  logic [DIVR_W:0]         trial;
  logic signed [DIVQ_W:0]  q_sgn;

  // ---------------- handshake and sequencing ----------------

  assign uc       = ucode(pc_r);
  assign go       = !(uc.wait_div && div_busy_r);
  assign run_go   = (state_r == S_RUN) && go;
  assign in_tready = (state_r == S_IDLE);
  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;
  assign in_dt    = in_tdata[23:0];
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    priority if (in_dt == '0) begin
      in_status = ST_ZERO;
    end else if (in_dt > maxdt_r) begin
      in_status = ST_LONG;
    end else begin
      in_status = ST_OK;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) begin
        state_nxt = (in_status == ST_OK) ? S_RUN : S_DONE;
      end
      S_RUN: if (go && uc.jmp == JMP_END) begin
        state_nxt = S_DONE;
      end
      S_DONE: if (out_free) begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    unique case (cfg_paddr[4:2])
      REG_ACCEL_GAIN: cfg_prdata = DATA_W'(ga_r);
      REG_RATE_GAIN:  cfg_prdata = DATA_W'(gr_r);
      REG_ACCEL_DB:   cfg_prdata = DATA_W'(adb_r);
      REG_RATE_DB:    cfg_prdata = DATA_W'(rdb_r);
      REG_MAX_DT:     cfg_prdata = DATA_W'(maxdt_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // ---------------- datapath ----------------

  always_comb begin
    unique case (ax_r)
      2'd0: begin
        vel_sel = vel_r[0];
        pos_sel = pos_r[0];
        ain_sel = ain_r[0];
      end
      2'd1: begin
        vel_sel = vel_r[1];
        pos_sel = pos_r[1];
        ain_sel = ain_r[1];
      end
      default: begin
        vel_sel = vel_r[2];
        pos_sel = pos_r[2];
        ain_sel = ain_r[2];
      end
    endcase
  end

  assign omg = (GAIN_W+1)'(1 << GAIN_W) - (GAIN_W+1)'(gr_r);

  always_comb begin
    unique case (uc.a_sel)
      A_TMP:   mul_a = MULA_W'(tmp_r);
      A_VEL:   mul_a = MULA_W'(vel_sel);
      A_DV:    mul_a = MULA_W'(dv_r);
      A_OMG:   mul_a = signed'(MULA_W'(omg));
      A_GR:    mul_a = signed'(MULA_W'(gr_r));
      default: mul_a = signed'(MULA_W'(ga_r));
    endcase
    unique case (uc.b_sel)
      B_GA:    mul_b = signed'(MULB_W'(ga_r));
      B_DT:    mul_b = signed'(MULB_W'(dt_r));
      B_RP:    mul_b = MULB_W'(rate_prev_r);
      B_RZ:    mul_b = MULB_W'(rz_r);
      default: mul_b = MULB_W'(ain_sel);
    endcase
  end

  assign prod_c = mul_a * mul_b;

  // round to nearest by 2^16, ties away from zero, then deadband
  always_comb begin
    rnd_sum  = ACC_W'(prod_r) + (uc.rnd_acc ? acc_r : '0);
    rnd_mag  = rnd_sum[ACC_W-1] ? ACC_W'(-rnd_sum) : ACC_W'(rnd_sum);
    rnd_sh   = (rnd_mag + (ACC_W'(1) << (GAIN_W-1))) >> GAIN_W;
    rnd_m    = rnd_sh[SMP_W-1:0];
    rnd_s    = rnd_sum[ACC_W-1] ? -signed'({1'b0, rnd_m}) : signed'({1'b0, rnd_m});
    rnd_dead = ((uc.rnd_op == RND_ACCEL) && (ax_r != 2'd2) && (rnd_m < {1'b0, adb_r})) ||
               ((uc.rnd_op == RND_RATE) && (rnd_m < {1'b0, rdb_r}));
    rnd_val  = rnd_dead ? '0 : rnd_s[SMP_W-1:0];
  end

  // divider: sign-magnitude with half the divisor added for rounding
  always_comb begin
    prod_mag = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
    div_n    = DIVN_W'(prod_mag) +
               DIVN_W'((uc.div_sel == DIV_SEL_2M) ? HALF_2M : HALF_1M);
    dvsr     = (div_dsel_r == DIV_SEL_2M) ? DIV_2M : DIV_1M;
    rem_c    = div_rem_r;
    quo_c    = div_quo_r;
    trial    = '0;
    for (int k = 0; k < DIV_DIGITS; k++) begin
      trial = {rem_c, quo_c[DIVQ_W-1]};
      quo_c = {quo_c[DIVQ_W-2:0], 1'b0};
      if (trial >= {1'b0, dvsr}) begin
        trial    = trial - {1'b0, dvsr};
        quo_c[0] = 1'b1;
      end
      rem_c = trial[DIVR_W-1:0];
    end
    q_sgn = div_neg_r ? -signed'({1'b0, div_quo_r}) : signed'({1'b0, div_quo_r});
  end

  // ---------------- control and architectural state ----------------

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pc_r         <= '0;
      ax_r         <= '0;
      ga_r         <= ACCEL_GAIN_RST;
      gr_r         <= RATE_GAIN_RST;
      adb_r        <= ACCEL_DB_RST;
      rdb_r        <= RATE_DB_RST;
      maxdt_r      <= MAX_DT_RST;
      for (int i = 0; i < 3; i++) begin
        vel_r[i] <= '0;
        pos_r[i] <= '0;
      end
      angle_r      <= '0;
      rate_prev_r  <= '0;
      div_busy_r   <= 1'b0;
      div_cnt_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr) begin
        unique case (cfg_paddr[4:2])
          REG_ACCEL_GAIN: ga_r    <= cfg_pwdata[GAIN_W-1:0];
          REG_RATE_GAIN:  gr_r    <= cfg_pwdata[GAIN_W-1:0];
          REG_ACCEL_DB:   adb_r   <= cfg_pwdata[DB_W-1:0];
          REG_RATE_DB:    rdb_r   <= cfg_pwdata[DB_W-1:0];
          REG_MAX_DT:     maxdt_r <= cfg_pwdata[DT_W-1:0];
          default: ;
        endcase
      end

      if (accept) begin
        pc_r <= '0;
        ax_r <= '0;
      end else if (run_go) begin
        unique case (uc.jmp)
          JMP_AXIS: begin
            if (ax_r != 2'd2) begin
              ax_r <= ax_r + 2'd1;
              pc_r <= '0;
            end else begin
              ax_r <= '0;
              pc_r <= pc_r + PC_W'(1);
            end
          end
          JMP_END:  pc_r <= '0;
          default:  pc_r <= pc_r + PC_W'(1);
        endcase
      end

      if (run_go && uc.rnd_op == RND_RATE) begin
        rate_prev_r <= rnd_val;
      end

      if (run_go && uc.wr_op == WR_POS) begin
        unique case (ax_r)
          2'd0: begin
            pos_r[0] <= sat32(acc_r + ACC_W'(q_sgn));
            vel_r[0] <= sat32(ACC_W'(vel_sel) + ACC_W'(dv_r));
          end
          2'd1: begin
            pos_r[1] <= sat32(acc_r + ACC_W'(q_sgn));
            vel_r[1] <= sat32(ACC_W'(vel_sel) + ACC_W'(dv_r));
          end
          default: begin
            pos_r[2] <= sat32(acc_r + ACC_W'(q_sgn));
            vel_r[2] <= sat32(ACC_W'(vel_sel) + ACC_W'(dv_r));
          end
        endcase
      end

      if (run_go && uc.wr_op == WR_ANG) begin
        angle_r <= sat32(ACC_W'(angle_r) + ACC_W'(q_sgn));
      end

      if (run_go && uc.div_start) begin
        div_busy_r <= 1'b1;
        div_cnt_r  <= '0;
      end else if (div_busy_r) begin
        div_cnt_r <= div_cnt_r + DIVC_W'(1);
        if (div_cnt_r == DIVC_W'(DIV_STEPS - 1)) begin
          div_busy_r <= 1'b0;
        end
      end

      if (state_r == S_DONE && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // ---------------- payload registers ----------------

  always_ff @(posedge clk) begin
    if (accept) begin
      dt_r     <= in_dt;
      ain_r[0] <= in_tdata[47:24];
      ain_r[1] <= in_tdata[71:48];
      ain_r[2] <= in_tdata[95:72];
      rz_r     <= in_tdata[119:96];
      status_r <= in_status;
    end

    if (state_r == S_RUN && uc.mul_en) begin
      prod_r <= prod_c;
    end

    if (run_go && uc.acc_ld) begin
      acc_r <= ACC_W'(prod_r);
    end else if (run_go && uc.wr_op == WR_PACC) begin
      acc_r <= ACC_W'(pos_sel) + ACC_W'(q_sgn);
    end

    if (run_go && uc.rnd_op != RND_NONE) begin
      tmp_r <= rnd_val;
    end

    if (run_go && uc.wr_op == WR_DV) begin
      dv_r <= q_sgn[DV_W-1:0];
    end

    if (run_go && uc.div_start) begin
      div_neg_r  <= prod_r[PROD_W-1];
      div_dsel_r <= uc.div_sel;
      div_rem_r  <= DIVR_W'(div_n[DIVN_W-1:DIVQ_W]);
      div_quo_r  <= div_n[DIVQ_W-1:0];
    end else if (div_busy_r) begin
      div_rem_r <= rem_c;
      div_quo_r <= quo_c;
    end

    if (state_r == S_DONE && out_free) begin
      out_data_r <= {rate_prev_r, angle_r, vel_r[2], vel_r[1], vel_r[0],
                     pos_r[2], pos_r[1], pos_r[0]};
      out_user_r <= status_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // ---------------- checks ----------------

  `IDR_ASSERT(a_div_free_at_start, (state_r == S_RUN) && go && uc.div_start, !div_busy_r)
  `IDR_ASSERT(a_seq_in_range, state_r == S_RUN, (pc_r <= UC_LAST) && (ax_r != 2'd3))
  `IDR_ASSERT(a_skip_keeps_state, (state_r == S_DONE) && (status_r != ST_OK), $stable(angle_r) && $stable(rate_prev_r))
  `IDR_ASSERT_NEXT(a_zero_dt_skips, accept && (in_dt == '0), state_r == S_DONE)

endmodule
